>>> design/i2a_pkg.sv
`timescale 1ns / 1ps

package i2a_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned RadixW    = 6;
  localparam int unsigned CharW     = 7;
  localparam int unsigned MaxDigits = 32;
  localparam int unsigned DigitAddrW = $clog2(MaxDigits);
  localparam int unsigned StepW     = $clog2(ValueW);

  localparam logic [RadixW-1:0] RadixMin     = 6'd2;
  localparam logic [RadixW-1:0] RadixMax     = 6'd36;
  localparam logic [RadixW-1:0] RadixDecimal = 6'd10;
  localparam logic [RadixW-1:0] DigitLimit   = 6'd9;

  localparam logic [CharW-1:0] CharZero  = 7'h30;
  localparam logic [CharW-1:0] CharA     = 7'h61;
  localparam logic [CharW-1:0] CharMinus = 7'h2d;

  localparam logic [StepW-1:0] StepLast = StepW'(ValueW - 1);

  // Request to the divider: load operands and start.
  typedef struct packed {
    logic                  start;
    logic [ValueW-1:0]     dividend;
    logic [RadixW-1:0]     divisor;
  } i2a_div_req_t;

  // Divider answer; done pulses for one cycle when quot and rem are valid.
  typedef struct packed {
    logic                  done;
    logic [ValueW-1:0]     quot;
    logic [RadixW-1:0]     rem;
  } i2a_div_res_t;

  // Digit value 0..35 to its ASCII character.
  function automatic logic [CharW-1:0] glyph(input logic [RadixW-1:0] d);
    logic [CharW-1:0] c;
    if (d > DigitLimit) begin
      c = CharA + CharW'(d) - CharW'(RadixDecimal);
    end else begin
      c = CharZero + CharW'(d);
    end
    return c;
  endfunction

endpackage

>>> design/i2a_ram.sv
`timescale 1ns / 1ps

module i2a_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/i2a_divider.sv
`timescale 1ns / 1ps

module i2a_divider import i2a_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  i2a_div_req_t req_i,
  output i2a_div_res_t res_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [ValueW-1:0] quo_q, quo_d;
  logic [RadixW-1:0] rem_q, rem_d;
  logic [RadixW-1:0] dvs_q, dvs_d;

  logic [RadixW:0]   trial;
  logic [RadixW:0]   diff;
  logic              fits;

  // One restoring step: bring down the next dividend bit and try to subtract.
  assign trial = {rem_q, quo_q[ValueW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d  = {quo_q[ValueW-2:0], fits};
      rem_d  = fits ? diff[RadixW-1:0] : trial[RadixW-1:0];
      step_d = step_q + 1'b1;
      if (step_q == StepLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = quo_q;
  assign res_o.rem  = rem_q;

endmodule

>>> design/integer_to_ascii_digits_unit.sv
`timescale 1ns / 1ps

// Each digit comes from the bit-serial divider (32 steps, then it hands back quotient and
// remainder); each character sent then takes a digit memory read and a hold until taken;
// a negative decimal number adds a sign character in front.
// One item at a time: a new number is taken only after the last character of the previous
// one has been taken.
// Reset clears the sequencer and the divider control; no item is in flight after it.
module integer_to_ascii_digits_unit import i2a_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [ValueW-1:0] value_i,
  input  logic [RadixW-1:0]        radix_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [CharW-1:0]         character_o,
  output logic                     last_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_SIGN = 5'b00100,
    ST_RD   = 5'b01000,
    ST_OUT  = 5'b10000
  } i2a_state_e;

  i2a_state_e            state_q, state_d;
  logic [DigitAddrW-1:0] ptr_q, ptr_d;
  logic                  minus_q, minus_d;
  logic [RadixW-1:0]     base_q, base_d;

  i2a_div_req_t          div_req;
  i2a_div_res_t          div_res;
  logic [RadixW-1:0]     base;
  logic                  in_minus;
  logic                  in_acc;
  logic                  out_acc;
  logic                  ram_we;
  logic                  ram_re;
  logic [CharW-1:0]      ram_rdata;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    if (radix_i < RadixMin) begin
      base = RadixMin;
    end else if (radix_i > RadixMax) begin
      base = RadixMax;
    end else begin
      base = radix_i;
    end
  end

  assign in_minus = (base == RadixDecimal) && value_i[ValueW-1];

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = div_res.quot;
    div_req.divisor  = base_q;
    if (state_q == ST_IDLE) begin
      div_req.start    = in_valid_i;
      div_req.dividend = in_minus ? ValueW'(-value_i) : ValueW'(value_i);
      div_req.divisor  = base;
    end else if (state_q == ST_DIV) begin
      // Keep dividing the quotient until it runs out, with the radix of this item.
      div_req.start = div_res.done && (div_res.quot != '0);
    end
  end

  i2a_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  assign ram_we = (state_q == ST_DIV) && div_res.done;
  assign ram_re = (state_q == ST_RD);

  i2a_ram #(
    .Width (CharW),
    .Depth (MaxDigits)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (glyph(div_res.rem)),
    .re_i    (ram_re),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    minus_d = minus_q;
    base_d  = base_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ptr_d   = '0;
          minus_d = in_minus;
          base_d  = base;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          if (div_res.quot != '0) begin
            ptr_d = ptr_q + 1'b1;
          end else begin
            state_d = minus_q ? ST_SIGN : ST_RD;
          end
        end
      end
      ST_SIGN: begin
        if (out_acc) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc) begin
          if (ptr_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            ptr_d   = ptr_q - 1'b1;
            state_d = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ptr_q   <= '0;
      minus_q <= 1'b0;
      base_q  <= RadixMin;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      minus_q <= minus_d;
      base_q  <= base_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_SIGN) || (state_q == ST_OUT);
  assign character_o = (state_q == ST_SIGN) ? CharMinus : ram_rdata;
  assign last_o      = (state_q == ST_OUT) && (ptr_q == '0);

  // The input and output sides never overlap within one item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a character is pending");

  // The final character hands control back to the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_o) |=> in_ready_o)
    else $error("block not idle after the last character");

  // The divider only finishes while the sequencer is waiting for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == ST_DIV))
    else $error("divider result outside the divide phase");

  // A sign is only ever produced for a negative decimal item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SIGN) |-> (minus_q && !last_o))
    else $error("sign emitted for a non-negative item");

endmodule

>>> bench/integer_to_ascii_digits_unit_test.sv
`timescale 1ns / 1ps

module integer_to_ascii_digits_unit_test;
  import i2a_pkg::*;

  localparam int unsigned QuietLimit = 20000;
  localparam int unsigned LongHold   = 4000;
  localparam int unsigned HoldAfter  = 300;
  localparam int unsigned RandomNums = 188;
  localparam int unsigned TailCycles = 100;

  typedef struct {
    logic [ValueW-1:0] value;
    logic [RadixW-1:0] radix;
  } number_req_t;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             last;
  } text_char_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic signed [ValueW-1:0] value_i = '0;
  logic [RadixW-1:0]        radix_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [CharW-1:0]         character_o;
  logic                     last_o;

  number_req_t pending_items[$];
  number_req_t next_req;
  text_char_t  expected_text[$];
  text_char_t  want;

  int unsigned items_total = 0;
  int unsigned items_accepted = 0;
  int unsigned chars_seen = 0;
  int unsigned neg_decimal_items = 0;
  int unsigned full_width_items = 0;
  int unsigned errors = 0;
  int unsigned offered = 0;
  int unsigned send_gap = 0;
  int unsigned take_gap = 0;
  int unsigned hold_left = 0;
  int unsigned rx_cycles = 0;
  int unsigned quiet_cycles = 0;
  logic        held_once = 1'b0;

  integer_to_ascii_digits_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .radix_i    (radix_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .character_o(character_o),
    .last_o     (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Appends the expected characters of one number, most significant first,
  // and returns how many there are.
  function automatic int unsigned predict_text(input logic [ValueW-1:0] bits,
                                               input logic [RadixW-1:0] radix_in);
    int unsigned      base;
    int unsigned      d;
    logic [ValueW-1:0] mag;
    logic             minus;
    logic [CharW-1:0] digits[$];
    base = radix_in;
    if (base < RadixMin) base = RadixMin;
    if (base > RadixMax) base = RadixMax;
    minus = (base == RadixDecimal) && bits[ValueW-1];
    mag = minus ? -bits : bits;
    if (mag == 0) digits.push_back(CharZero);
    while (mag != 0) begin
      d = mag % base;
      digits.push_back((d > DigitLimit) ? CharA + CharW'(d - RadixDecimal)
                                        : CharZero + CharW'(d));
      mag = mag / base;
    end
    if (minus) digits.push_back(CharMinus);
    for (int k = digits.size() - 1; k >= 0; k--) begin
      expected_text.push_back('{character: digits[k], last: (k == 0)});
    end
    return digits.size();
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(40, 250);
  endfunction

  task automatic add_item(input logic [ValueW-1:0] v, input logic [RadixW-1:0] r);
    pending_items.push_back('{value: v, radix: r});
    items_total++;
  endtask

  function automatic logic [ValueW-1:0] random_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 99);
      2: return -$urandom_range(1, 5000);
      3: return (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
      4: return {1'b1, 31'($urandom)};
      default: return $urandom_range(0, 1000000);
    endcase
  endfunction

  function automatic logic [RadixW-1:0] random_radix();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return RadixW'($urandom_range(RadixMin, RadixMax));
    if (r < 85) return RadixMin;
    if (r < 90) return RadixDecimal;
    return RadixW'($urandom_range(0, 63));
  endfunction

  // Sender: valid stays up with a steady payload until the item is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else if (in_valid_i && !in_ready_o) begin
      in_valid_i <= 1'b1;
    end else if (send_gap != 0) begin
      in_valid_i <= 1'b0;
      send_gap   <= send_gap - 1;
    end else if (pending_items.size() != 0) begin
      next_req = pending_items.pop_front();
      in_valid_i <= 1'b1;
      value_i    <= next_req.value;
      radix_i    <= next_req.radix;
      send_gap   <= ((offered / 30) % 4 == 2) ? 0 : idle_len();
      offered    <= offered + 1;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver: random stalls, a calm window now and then, and one long hold-off
  // that backs the block up while the sender keeps offering.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      take_gap    <= 0;
      hold_left   <= 0;
      held_once   <= 1'b0;
      rx_cycles   <= 0;
    end else begin
      rx_cycles <= rx_cycles + 1;
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left   <= hold_left - 1;
      end else if (!held_once && chars_seen >= HoldAfter) begin
        held_once   <= 1'b1;
        hold_left   <= LongHold;
        out_ready_i <= 1'b0;
      end else if (take_gap != 0) begin
        out_ready_i <= 1'b0;
        take_gap    <= take_gap - 1;
      end else if ((rx_cycles / 3000) % 4 != 3 && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        take_gap    <= idle_len();
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: predicts on every accepted number, checks every accepted character.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (predict_text(value_i, radix_i) == MaxDigits) full_width_items++;
        if (radix_i == RadixDecimal && value_i < 0) neg_decimal_items++;
        items_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        chars_seen <= chars_seen + 1;
        if (expected_text.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: unexpected character 0x%02h last=%0b", character_o, last_o);
        end else begin
          want = expected_text.pop_front();
          if (want.character !== character_o || want.last !== last_o) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: character %0d: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                       chars_seen, want.character, want.last, character_o, last_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Timeout: no transfer for %0d cycles", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Zero, the extremes of the value in the interesting radixes, and the
    // saturation of out-of-range radixes at both ends.
    add_item(32'd0, RadixDecimal);
    add_item(32'd0, RadixMin);
    add_item(32'd0, RadixMax);
    add_item(32'h8000_0000, RadixDecimal);
    add_item(32'h8000_0000, RadixMin);
    add_item(32'h8000_0000, 6'd16);
    add_item(32'h7fff_ffff, RadixDecimal);
    add_item(32'h7fff_ffff, RadixMax);
    add_item(32'hffff_ffff, RadixDecimal);
    add_item(32'hffff_ffff, RadixMin);
    add_item(32'hffff_ffff, RadixMax);
    add_item(32'd5, 6'd0);
    add_item(32'd5, 6'd1);
    add_item(32'd1295, 6'd37);
    add_item(32'hffff_ffff, 6'd63);
    add_item(32'd35, RadixMax);
    add_item(32'd9, RadixDecimal);
    add_item(32'd10, 6'd16);
    add_item(32'd1, RadixDecimal);
    add_item(-32'sd42, RadixDecimal);
    add_item(32'd12345, 6'd8);
    add_item(32'd1000, 6'd3);
    for (int i = 0; i < RandomNums; i++) add_item(random_value(), random_radix());

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_accepted < items_total) @(negedge clk_i);
    while (expected_text.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    $display("Converted %0d numbers into %0d characters.", items_accepted, chars_seen);
    $display("Negative decimal numbers: %0d, full 32-digit binary numbers: %0d.",
             neg_decimal_items, full_width_items);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/i2a_pkg.sv
design/i2a_ram.sv
design/i2a_divider.sv
design/integer_to_ascii_digits_unit.sv
bench/integer_to_ascii_digits_unit_test.sv
